>>> rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg: shared types and constants of the frame stream deframer
// Command codes passed from the parser to the result sequencer, result kinds,
// parser phases and the reply byte table.
// ----------------------------------------------------------------------------
package fsd_pkg;

  // Result kinds on the output channel
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MAX_CONTROL_LEN = 1'b0;
  localparam logic CFG_MAX_DATA_LEN    = 1'b1;

  // Control frame types that cause a reply
  localparam logic [31:0] TYPE_READY = 32'd4;
  localparam logic [31:0] TYPE_STOP  = 32'd3;

  // Reply lengths in bytes
  localparam logic [5:0] ACCEPT_LEN = 6'd42;
  localparam logic [5:0] FINISH_LEN = 6'd12;

  // Parser phases
  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_CLEN = 3'd1,
    PH_CTRL = 3'd2,
    PH_DATA = 3'd3,
    PH_DEAD = 3'd4
  } phase_t;

  // Commands queued between parser and sequencer
  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_ACCEPT = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_ERROR  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // Reply byte table: ACCEPT carries the content type string, FINISH is
  // an escape, a control length and the FINISH type word.
  function automatic logic [7:0] reply_byte(input logic is_finish, input logic [5:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (is_finish) begin
      case (idx)
        6'd7:    b = 8'h04;
        6'd11:   b = 8'h05;
        default: b = 8'h00;
      endcase
    end else begin
      case (idx)
        6'd7:    b = 8'h22;
        6'd11:   b = 8'h01;
        6'd15:   b = 8'h01;
        6'd19:   b = 8'h16;
        6'd20:   b = 8'h70; // p
        6'd21:   b = 8'h72; // r
        6'd22:   b = 8'h6f; // o
        6'd23:   b = 8'h74; // t
        6'd24:   b = 8'h6f; // o
        6'd25:   b = 8'h62; // b
        6'd26:   b = 8'h75; // u
        6'd27:   b = 8'h66; // f
        6'd28:   b = 8'h3a; // :
        6'd29:   b = 8'h64; // d
        6'd30:   b = 8'h6e; // n
        6'd31:   b = 8'h73; // s
        6'd32:   b = 8'h74; // t
        6'd33:   b = 8'h61; // a
        6'd34:   b = 8'h70; // p
        6'd35:   b = 8'h2e; // .
        6'd36:   b = 8'h44; // D
        6'd37:   b = 8'h6e; // n
        6'd38:   b = 8'h73; // s
        6'd39:   b = 8'h74; // t
        6'd40:   b = 8'h61; // a
        6'd41:   b = 8'h70; // p
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

>>> rtl/fsd_front.sv
// ----------------------------------------------------------------------------
// fsd_front: frame parser
// Takes one stream byte per transaction, tracks frame headers and lengths,
// and issues at most one command per byte to the command queue.
// ----------------------------------------------------------------------------
module fsd_front #(
  parameter int LEN_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic [31:0]   max_control_len,
  input  logic [31:0]   max_data_len,
  output logic          cmd_valid,
  output fsd_pkg::cmd_t cmd
);
  import fsd_pkg::*;

  phase_t                phase, phase_next;
  logic [1:0]            hdr_count, hdr_count_next;
  logic [23:0]           len_acc, len_acc_next;
  logic [LEN_BITS-1:0]   remain, remain_next;
  logic [31:0]           type_word, type_word_next;
  logic [2:0]            type_count, type_count_next;

  logic [31:0]           len_word;
  logic                  too_wide;
  logic                  hdr_done;
  logic [LEN_BITS-1:0]   remain_dec;
  logic                  remain_zero;
  logic [31:0]           type_word_upd;
  logic [2:0]            type_count_upd;
  logic                  len_bad_data;
  logic                  len_bad_ctrl;

  // Shared datapath terms
  assign len_word       = {len_acc, in_byte};
  assign hdr_done       = (hdr_count == 2'd3);
  assign remain_dec     = remain - 1'b1;
  assign remain_zero    = (remain_dec == '0);
  assign type_word_upd  = (type_count < 3'd4) ? {type_word[23:0], in_byte} : type_word;
  assign type_count_upd = (type_count < 3'd4) ? type_count + 3'd1 : type_count;

  // Length that does not fit the counter
  if (LEN_BITS < 32) begin : g_narrow
    assign too_wide = |len_word[31:LEN_BITS];
  end else begin : g_full
    assign too_wide = 1'b0;
  end

  assign len_bad_data = (len_word > max_data_len) || too_wide;
  assign len_bad_ctrl = (len_word > max_control_len) || too_wide;

  // Next state
  always_comb begin
    phase_next      = phase;
    hdr_count_next  = hdr_count;
    len_acc_next    = len_acc;
    remain_next     = remain;
    type_word_next  = type_word;
    type_count_next = type_count;
    if (in_valid) begin
      case (phase)
        PH_LEN, PH_CLEN: begin
          if (!hdr_done) begin
            len_acc_next   = {len_acc[15:0], in_byte};
            hdr_count_next = hdr_count + 2'd1;
          end else begin
            hdr_count_next = 2'd0;
            remain_next    = len_word[LEN_BITS-1:0];
            if (phase == PH_LEN) begin
              if (len_word == 32'd0)  phase_next = PH_CLEN;
              else if (len_bad_data) phase_next = PH_DEAD;
              else                   phase_next = PH_DATA;
            end else begin
              if (len_bad_ctrl) begin
                phase_next = PH_DEAD;
              end else if (len_word == 32'd0) begin
                phase_next = PH_LEN;
              end else begin
                phase_next      = PH_CTRL;
                type_word_next  = 32'd0;
                type_count_next = 3'd0;
              end
            end
          end
        end
        PH_CTRL: begin
          type_word_next  = type_word_upd;
          type_count_next = type_count_upd;
          remain_next     = remain_dec;
          if (remain_zero) phase_next = PH_LEN;
        end
        PH_DATA: begin
          remain_next = remain_dec;
          if (remain_zero) phase_next = PH_LEN;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Command output
  always_comb begin
    cmd_valid = 1'b0;
    cmd.kind  = CMD_DATA;
    cmd.data  = in_byte;
    cmd.last  = remain_zero;
    if (in_valid) begin
      case (phase)
        PH_LEN: begin
          if (hdr_done && len_word != 32'd0 && len_bad_data) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_ERROR;
          end
        end
        PH_CLEN: begin
          if (hdr_done && len_bad_ctrl) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_ERROR;
          end
        end
        PH_CTRL: begin
          if (remain_zero && type_count_upd == 3'd4) begin
            if (type_word_upd == TYPE_READY) begin
              cmd_valid = 1'b1;
              cmd.kind  = CMD_ACCEPT;
            end else if (type_word_upd == TYPE_STOP) begin
              cmd_valid = 1'b1;
              cmd.kind  = CMD_FINISH;
            end
          end
        end
        PH_DATA: begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_DATA;
        end
        default: begin
          cmd_valid = 1'b0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEN;
      hdr_count  <= 2'd0;
      type_count <= 3'd0;
    end else begin
      phase      <= phase_next;
      hdr_count  <= hdr_count_next;
      type_count <= type_count_next;
    end
  end

  always_ff @(posedge clk) begin
    len_acc   <= len_acc_next;
    remain    <= remain_next;
    type_word <= type_word_next;
  end

  // A fatal error is final until reset
  a_dead_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DEAD |=> phase == PH_DEAD)
    else $error("parser left the error phase");

  // An error command always moves the parser to the error phase
  a_error_dead: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.kind == CMD_ERROR |=> phase == PH_DEAD)
    else $error("error command without entering error phase");

endmodule

>>> rtl/fsd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fsd_cmd_fifo: command queue
// Small register queue that decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
module fsd_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  fsd_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output fsd_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import fsd_pkg::*;

  localparam int DEPTH  = 4;
  localparam int AW     = $clog2(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign full   = (count == (AW+1)'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("command queue overfilled");

endmodule

>>> rtl/fsd_back.sv
// ----------------------------------------------------------------------------
// fsd_back: result sequencer
// Pops commands, expands reply commands into their byte bursts, and keeps
// the result in an output register toward the receiver.
// ----------------------------------------------------------------------------
module fsd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  fsd_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          pop,
  output logic          empty,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_byte,
  output logic          last
);
  import fsd_pkg::*;

  logic       out_valid;
  logic       reply_active;
  logic       reply_finish;
  logic [5:0] reply_idx;
  logic [5:0] reply_len;
  logic       load;
  logic       reply_end;

  assign empty     = !out_valid;
  assign load      = !out_valid || pop;
  assign cmd_pop   = load && !reply_active && !cmd_empty;
  assign reply_len = reply_finish ? FINISH_LEN : ACCEPT_LEN;
  assign reply_end = (reply_idx == reply_len - 6'd1);

  // Control: output valid and reply burst position
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      reply_active <= 1'b0;
      reply_finish <= 1'b0;
      reply_idx    <= 6'd0;
    end else if (load) begin
      if (reply_active) begin
        out_valid <= 1'b1;
        reply_idx <= reply_idx + 6'd1;
        if (reply_end) reply_active <= 1'b0;
      end else if (!cmd_empty) begin
        out_valid <= 1'b1;
        if (cmd.kind == CMD_ACCEPT || cmd.kind == CMD_FINISH) begin
          reply_active <= 1'b1;
          reply_finish <= (cmd.kind == CMD_FINISH);
          reply_idx    <= 6'd1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (reply_active) begin
        out_kind <= KIND_REPLY;
        out_byte <= reply_byte(reply_finish, reply_idx);
        last     <= reply_end;
      end else if (!cmd_empty) begin
        case (cmd.kind)
          CMD_DATA: begin
            out_kind <= KIND_DATA;
            out_byte <= cmd.data;
            last     <= cmd.last;
          end
          CMD_ACCEPT: begin
            out_kind <= KIND_REPLY;
            out_byte <= reply_byte(1'b0, 6'd0);
            last     <= 1'b0;
          end
          CMD_FINISH: begin
            out_kind <= KIND_REPLY;
            out_byte <= reply_byte(1'b1, 6'd0);
            last     <= 1'b0;
          end
          default: begin
            out_kind <= KIND_ERROR;
            out_byte <= 8'h00;
            last     <= 1'b0;
          end
        endcase
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    reply_active |-> reply_idx < reply_len)
    else $error("reply index past end of reply");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

endmodule

>>> rtl/frame_stream_deframer_core.sv
// ----------------------------------------------------------------------------
// frame_stream_deframer_core: Frame Streams deframer
// Splits a received byte stream into data frame payload bytes, control
// replies and a fatal error indication.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one stream byte per transaction (push while full is low).
//   Result channel: queue style; a result is shown while empty is low and
//   is taken with pop. Each result is a data byte (last on the final byte
//   of a frame), a reply byte (last on the final byte of the reply), or a
//   single fatal error, after which every input byte is dropped until reset.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 max_control_len, 1 max_data_len); write only while idle.
//   Throughput: one input byte per cycle while full is low. A data byte
//   passes the command queue and then the output register before it is on
//   the result ports. A READY or STOP control frame yields a burst of
//   42 or 12 reply bytes, one per cycle from the result sequencer while
//   the receiver pops; input keeps flowing into a four-entry command queue
//   meanwhile, and full rises once that queue fills.
//   Reset: parser waits for a frame length, queues and output are emptied,
//   limits return to 512 and 65536.
//   Receiver stall: the output register holds its result, the command queue
//   fills, then full holds off the sender.
// ----------------------------------------------------------------------------
module frame_stream_deframer_core #(
  parameter int LEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import fsd_pkg::*;

  logic [31:0] max_control_len;
  logic [31:0] max_data_len;
  logic        in_valid;
  logic        cmd_valid;
  cmd_t        cmd_in;
  cmd_t        cmd_out;
  logic        cmd_pop;
  logic        cmd_empty;

  assign in_valid = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_control_len <= 32'd512;
      max_data_len    <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_CONTROL_LEN: max_control_len <= cfg_data;
        CFG_MAX_DATA_LEN:    max_data_len    <= cfg_data;
        default:             max_data_len    <= max_data_len;
      endcase
    end
  end

  fsd_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_byte         (in_byte),
    .max_control_len (max_control_len),
    .max_data_len    (max_data_len),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd_in)
  );

  fsd_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_valid),
    .wr_cmd (cmd_in),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_out),
    .full   (full),
    .empty  (cmd_empty)
  );

  fsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule
